[hw/rtl/nsc_pkg.sv]
// shared types and character constants for the nmea sentence checker
package nsc_pkg;

  localparam int unsigned CountW = 7;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam int unsigned WindowDepth = 3;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChBang   = 8'h21;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChComma  = 8'h2C;

  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StEmpty      = 3'd1,
    StBadStart   = 3'd2,
    StBadTrailer = 3'd3,
    StTooLong    = 3'd4
  } status_e;

  typedef enum logic {
    KindByte = 1'b0,
    KindEol  = 1'b1
  } kind_e;

  // line state handed from the tracker to the trailer evaluation
  typedef struct packed {
    logic [CountW-1:0] byte_count;
    logic [7:0]        start_byte;
    logic [7:0]        win0;
    logic [7:0]        win1;
    logic [7:0]        win2;
    logic [7:0]        body_xor;
    logic [CountW-1:0] comma_count;
    logic              last_comma;
  } line_state_t;

  typedef struct packed {
    status_e           status;
    logic              encapsulated;
    logic [7:0]        computed_sum;
    logic [7:0]        received_sum;
    logic [CountW-1:0] field_count;
  } result_t;

endpackage

[hw/rtl/nmea_sentence_checker.sv]
// top level of the nmea 0183 sentence checker
// The checker takes a sentence one byte per request (kind 0) and closes it
// with an end-of-line request (kind 1), which yields exactly one result:
// status, start-byte type, computed and received checksum and field count.
// Byte requests yield no result. Each request is registered on entry and
// handled from that register, so one request is taken every cycle; the only
// stall comes from an end-of-line request that finds the result register
// still full and held by the downstream side. The result register loads as
// the end-of-line request leaves the input register. Lines with a valid start
// byte longer than MAX_LINE_LENGTH bytes (4..126) report status too long.
module nmea_sentence_checker
  import nsc_pkg::*;
#(
  parameter int unsigned MAX_LINE_LENGTH = 82
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request side
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  byte_value_i,
  // result side
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        encapsulated_o,
  output logic [7:0]  computed_sum_o,
  output logic [7:0]  received_sum_o,
  output logic [6:0]  field_count_o
);

  // input register
  logic       req_valid_q;
  logic       req_kind_q;
  logic [7:0] req_byte_q;
  // result register
  logic       out_valid_q;
  result_t    out_q;

  line_state_t line_state;
  result_t     result;
  logic        req_is_eol;
  logic        req_advance;
  logic        in_accept;

  assign req_is_eol = req_valid_q && (kind_e'(req_kind_q) == KindEol);

  // an end-of-line request waits only while the result register is held
  assign req_advance = !(req_is_eol && out_valid_q && out_stall_i);
  assign in_stall_o  = req_valid_q && !req_advance;
  assign in_accept   = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_advance) begin
      req_valid_q <= in_accept;
    end
  end

  // payload holds while stalled
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_kind_q <= kind_i;
      req_byte_q <= byte_value_i;
    end
  end

  // state update for the registered request
  nsc_line_tracker u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (req_valid_q && req_advance),
    .kind_i       (req_kind_q),
    .byte_value_i (req_byte_q),
    .state_o      (line_state)
  );

  // result from the state left by the bytes before end of line
  nsc_trailer_eval #(
    .MAX_LINE_LENGTH (MAX_LINE_LENGTH)
  ) u_eval (
    .state_i  (line_state),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (req_is_eol && req_advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_is_eol && req_advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign encapsulated_o = out_q.encapsulated;
  assign computed_sum_o = out_q.computed_sum;
  assign received_sum_o = out_q.received_sum;
  assign field_count_o  = out_q.field_count;

endmodule

[hw/rtl/nsc_line_tracker.sv]
// per-line state: byte count, start byte, tail window, body xor and comma count
module nsc_line_tracker
  import nsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        kind_i,
  input  logic [7:0]  byte_value_i,
  output line_state_t state_o
);

  line_state_t state_q, state_d;
  logic [7:0]  old_byte;

  assign old_byte = state_q.win0;

  always_comb begin
    state_d = state_q;
    if (step_i) begin
      if (kind_e'(kind_i) == KindEol) begin
        state_d = '0;
      end else begin
        if (state_q.byte_count == '0) begin
          state_d.start_byte = byte_value_i;
        end else begin
          // oldest byte leaves the window once three body bytes wait
          if (state_q.byte_count >= CountW'(4)) begin
            state_d.body_xor   = state_q.body_xor ^ old_byte;
            state_d.last_comma = (old_byte == ChComma);
            if (old_byte == ChComma && state_q.comma_count != CountMax) begin
              state_d.comma_count = state_q.comma_count + CountW'(1);
            end
          end
          state_d.win0 = state_q.win1;
          state_d.win1 = state_q.win2;
          state_d.win2 = byte_value_i;
        end
        if (state_q.byte_count != CountMax) begin
          state_d.byte_count = state_q.byte_count + CountW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

[hw/rtl/nsc_trailer_eval.sv]
// end-of-line evaluation: start byte, length and checksum trailer
module nsc_trailer_eval
  import nsc_pkg::*;
#(
  parameter int unsigned MAX_LINE_LENGTH = 82
) (
  input  line_state_t state_i,
  output result_t     result_o
);

  localparam logic [CountW-1:0] MaxLen = CountW'(MAX_LINE_LENGTH);

  logic [3:0] hi_val, lo_val;
  logic       hi_ok, lo_ok, digits_ok, too_long;
  logic [7:0] rsum;

  always_comb begin
    hi_ok  = 1'b1;
    hi_val = 4'd0;
    if (state_i.win1 >= 8'h30 && state_i.win1 <= 8'h39) begin
      hi_val = state_i.win1[3:0];
    end else if (state_i.win1 >= 8'h41 && state_i.win1 <= 8'h46) begin
      hi_val = state_i.win1[3:0] + 4'd9;
    end else begin
      hi_ok = 1'b0;
    end
    lo_ok  = 1'b1;
    lo_val = 4'd0;
    if (state_i.win2 >= 8'h30 && state_i.win2 <= 8'h39) begin
      lo_val = state_i.win2[3:0];
    end else if (state_i.win2 >= 8'h41 && state_i.win2 <= 8'h46) begin
      lo_val = state_i.win2[3:0] + 4'd9;
    end else begin
      lo_ok = 1'b0;
    end
  end

  assign digits_ok = hi_ok && lo_ok;
  assign rsum      = digits_ok ? {hi_val, lo_val} : 8'd0;
  assign too_long  = state_i.byte_count > MaxLen;

  always_comb begin
    result_o = '0;
    result_o.status = StOk;
    if (state_i.byte_count == '0) begin
      result_o.status = StEmpty;
    end else if (state_i.start_byte != ChDollar && state_i.start_byte != ChBang) begin
      result_o.status = StBadStart;
    end else begin
      result_o.encapsulated = (state_i.start_byte == ChBang);
      if (state_i.byte_count >= CountW'(4)) begin
        result_o.computed_sum = state_i.body_xor;
        result_o.received_sum = rsum;
        if (state_i.byte_count > CountW'(4)) begin
          result_o.field_count = state_i.comma_count
                                 + CountW'(!state_i.last_comma);
        end
        if (too_long) begin
          result_o.status = StTooLong;
        end else if (state_i.win0 != ChStar || !digits_ok
                     || rsum != state_i.body_xor) begin
          result_o.status = StBadTrailer;
        end
      end else begin
        result_o.status = too_long ? StTooLong : StBadTrailer;
      end
    end
  end

endmodule
